// File: rtl/core/pbrs_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pbrs_pkg
// Shared types, codes and defaults for the protobuf record splitter.
// -----------------------------------------------------------------------------
package pbrs_pkg;

   localparam int ACC_W      = 64;         // varint accumulator
   localparam int ACC_EXT_W  = ACC_W + 7;  // accumulator plus one shifted 7-bit group
   localparam int FIELD_W    = 61;
   localparam int WT_W       = 3;
   localparam int LEN_OUT_W  = 31;
   localparam int ROLE_W     = 2;
   localparam int ERR_W      = 3;

   localparam int DEF_MAX_VARINT_BYTES = 10;
   localparam int DEF_LENGTH_BITS      = 31;

   localparam int FIXED64_BYTES = 8;
   localparam int FIXED32_BYTES = 4;

   // wire types
   localparam logic [WT_W-1:0] WT_VARINT  = 3'd0;
   localparam logic [WT_W-1:0] WT_FIXED64 = 3'd1;
   localparam logic [WT_W-1:0] WT_LENGTH  = 3'd2;
   localparam logic [WT_W-1:0] WT_SGROUP  = 3'd3;
   localparam logic [WT_W-1:0] WT_EGROUP  = 3'd4;
   localparam logic [WT_W-1:0] WT_FIXED32 = 3'd5;

   // byte roles
   localparam logic [ROLE_W-1:0] ROLE_TAG     = 2'd0;
   localparam logic [ROLE_W-1:0] ROLE_LENGTH  = 2'd1;
   localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 2'd2;
   localparam logic [ROLE_W-1:0] ROLE_SKIP    = 2'd3;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_OVERLONG  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_BAD_WT    = 3'd2;
   localparam logic [ERR_W-1:0] ERR_TOO_LONG  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd4;

   typedef enum logic [2:0] {
      PH_TAG,
      PH_LEN,
      PH_VPAY,
      PH_PAY,
      PH_SKIP
   } phase_type;

   typedef struct packed {
      logic done;      // terminating byte taken
      logic overlong;  // too many bytes or bits beyond 64
   } varint_status_type;

   typedef struct packed {
      logic [7:0]           out_byte;
      logic [ROLE_W-1:0]    byte_role;
      logic [FIELD_W-1:0]   field_number;
      logic [WT_W-1:0]      wire_type;
      logic [LEN_OUT_W-1:0] payload_length;
      logic                 record_end;
      logic [ERR_W-1:0]     error_code;
   } rsp_type;

endpackage

// File: rtl/core/pbrs_varint.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pbrs_varint
// One byte step of a little-endian base-128 varint: merge, overflow check.
// -----------------------------------------------------------------------------
module pbrs_varint import pbrs_pkg::*; #(
   parameter int MAX_VARINT_BYTES = DEF_MAX_VARINT_BYTES,
   parameter int CNT_W            = $clog2(MAX_VARINT_BYTES + 1)
) (
   input  logic [7:0]        in_byte,
   input  logic [ACC_W-1:0]  acc,
   input  logic [CNT_W-1:0]  cnt,
   output logic [ACC_W-1:0]  acc_next,
   output logic [CNT_W-1:0]  cnt_next,
   output varint_status_type status
);

   localparam int SHIFT_W = $clog2(7 * MAX_VARINT_BYTES);

   logic [SHIFT_W-1:0]   shift;
   logic [ACC_EXT_W-1:0] shifted;
   logic                 bits_lost;

   always_comb begin
      shift     = SHIFT_W'(7 * cnt);
      shifted   = ACC_EXT_W'(in_byte[6:0]) << shift;
      // any group bit landing above bit 63 cannot be represented
      bits_lost = |shifted[ACC_EXT_W-1:ACC_W];
      acc_next  = acc | shifted[ACC_W-1:0];
      cnt_next  = cnt + CNT_W'(1);
      status.done     = !bits_lost && !in_byte[7];
      status.overlong = bits_lost ||
                        (in_byte[7] && (cnt_next >= CNT_W'(MAX_VARINT_BYTES)));
   end

endmodule

// File: rtl/core/pbrs_in_reg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pbrs_in_reg
// Input register stage; takes a new item whenever it is empty or draining.
// -----------------------------------------------------------------------------
module pbrs_in_reg import pbrs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_message_last,
   input  logic       take,
   output logic       held_valid,
   output logic [7:0] held_byte,
   output logic       held_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_in_byte;
         last_ff <= req_message_last;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;
   assign held_last  = last_ff;

endmodule

// File: rtl/core/pbrs_decoder.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pbrs_decoder
// Record state machine: tag, length prefix and payload tracking per byte.
// -----------------------------------------------------------------------------
module pbrs_decoder import pbrs_pkg::*; #(
   parameter int MAX_VARINT_BYTES = DEF_MAX_VARINT_BYTES,
   parameter int LENGTH_BITS      = DEF_LENGTH_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output rsp_type    result
);

   localparam int CNT_W = $clog2(MAX_VARINT_BYTES + 1);

   phase_type               phase_ff, phase_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [FIELD_W-1:0]      field_ff, field_in;
   logic [WT_W-1:0]         wt_ff, wt_in;
   logic [LENGTH_BITS-1:0]  remain_ff, remain_in;
   logic [LENGTH_BITS-1:0]  decl_ff, decl_in;

   logic [ACC_W-1:0]        v_acc;
   logic [CNT_W-1:0]        v_cnt;
   varint_status_type       v_stat;

   logic [WT_W-1:0]         tag_wt;
   logic [FIELD_W-1:0]      tag_field;
   logic [LENGTH_BITS-1:0]  tag_decl;
   logic [LENGTH_BITS-1:0]  prefix;
   logic                    len_ok;
   logic [LENGTH_BITS-1:0]  remain_next;
   logic [ERR_W-1:0]        err_raw;
   logic [ERR_W-1:0]        err_final;
   phase_type               phase_norm;
   logic [CNT_W-1:0]        cnt_norm;
   logic                    varint_phase;

   pbrs_varint #(
      .MAX_VARINT_BYTES(MAX_VARINT_BYTES),
      .CNT_W           (CNT_W)
   ) u_varint (
      .in_byte (in_byte),
      .acc     (acc_ff),
      .cnt     (cnt_ff),
      .acc_next(v_acc),
      .cnt_next(v_cnt),
      .status  (v_stat)
   );

   // shared decode: error, phase before error/end handling
   always_comb begin
      tag_wt       = v_acc[WT_W-1:0];
      tag_field    = v_acc[ACC_W-1:WT_W];
      prefix       = v_acc[LENGTH_BITS-1:0];
      len_ok       = v_stat.done && !(|v_acc[ACC_W-1:LENGTH_BITS]);
      remain_next  = (remain_ff != '0) ? remain_ff - LENGTH_BITS'(1) : remain_ff;
      varint_phase = (phase_ff == PH_TAG) || (phase_ff == PH_LEN) || (phase_ff == PH_VPAY);

      case (tag_wt)
         WT_FIXED64: tag_decl = LENGTH_BITS'(FIXED64_BYTES);
         WT_FIXED32: tag_decl = LENGTH_BITS'(FIXED32_BYTES);
         default:    tag_decl = '0;
      endcase

      err_raw    = ERR_NONE;
      phase_norm = phase_ff;
      case (phase_ff)
         PH_TAG: begin
            if (v_stat.overlong) begin
               err_raw = ERR_OVERLONG;
            end else if (v_stat.done) begin
               case (tag_wt)
                  WT_VARINT:             phase_norm = PH_VPAY;
                  WT_FIXED64:            phase_norm = PH_PAY;
                  WT_LENGTH:             phase_norm = PH_LEN;
                  WT_FIXED32:            phase_norm = PH_PAY;
                  WT_SGROUP, WT_EGROUP:  phase_norm = PH_TAG;
                  default:               err_raw    = ERR_BAD_WT;
               endcase
            end
         end
         PH_LEN: begin
            if (v_stat.overlong) begin
               err_raw = ERR_OVERLONG;
            end else if (v_stat.done && !len_ok) begin
               err_raw = ERR_TOO_LONG;
            end else if (len_ok) begin
               phase_norm = (prefix == '0) ? PH_TAG : PH_PAY;
            end
         end
         PH_VPAY: begin
            if (v_stat.overlong) begin
               err_raw = ERR_OVERLONG;
            end else if (v_stat.done) begin
               phase_norm = PH_TAG;
            end
         end
         PH_PAY: begin
            if (remain_next == '0) begin
               phase_norm = PH_TAG;
            end
         end
         default: begin
            phase_norm = PH_SKIP;
         end
      endcase

      if (varint_phase) begin
         cnt_norm = v_stat.done ? '0 : v_cnt;
      end else begin
         cnt_norm = cnt_ff;
      end

      // message ended inside a record
      if (err_raw != ERR_NONE) begin
         err_final = err_raw;
      end else if (in_last && (phase_norm != PH_SKIP) &&
                   ((phase_norm != PH_TAG) || (cnt_norm != '0))) begin
         err_final = ERR_TRUNCATED;
      end else begin
         err_final = ERR_NONE;
      end
   end

   // next state
   always_comb begin
      phase_in  = phase_norm;
      cnt_in    = cnt_norm;
      acc_in    = acc_ff;
      field_in  = field_ff;
      wt_in     = wt_ff;
      remain_in = remain_ff;
      decl_in   = decl_ff;

      if (varint_phase) begin
         acc_in = v_stat.done ? '0 : v_acc;
      end

      case (phase_ff)
         PH_TAG: begin
            if (v_stat.done) begin
               field_in  = tag_field;
               wt_in     = tag_wt;
               decl_in   = tag_decl;
               remain_in = tag_decl;
            end
         end
         PH_LEN: begin
            if (len_ok) begin
               decl_in   = prefix;
               remain_in = prefix;
            end
         end
         PH_PAY: begin
            remain_in = remain_next;
         end
         default: begin
         end
      endcase

      if (err_raw != ERR_NONE) begin
         phase_in = PH_SKIP;
      end

      if (in_last) begin
         phase_in = PH_TAG;
         cnt_in   = '0;
         acc_in   = '0;
      end
   end

   // outputs
   always_comb begin
      result.out_byte       = in_byte;
      result.byte_role      = ROLE_SKIP;
      result.field_number   = '0;
      result.wire_type      = '0;
      result.payload_length = '0;
      result.record_end     = 1'b0;
      result.error_code     = err_final;

      case (phase_ff)
         PH_TAG: begin
            result.byte_role = ROLE_TAG;
            if (v_stat.done) begin
               result.field_number   = tag_field;
               result.wire_type      = tag_wt;
               result.payload_length = LEN_OUT_W'(tag_decl);
               result.record_end     = (tag_wt == WT_SGROUP) || (tag_wt == WT_EGROUP);
            end
         end
         PH_LEN: begin
            result.byte_role    = ROLE_LENGTH;
            result.field_number = field_ff;
            result.wire_type    = wt_ff;
            if (len_ok) begin
               result.payload_length = LEN_OUT_W'(prefix);
               result.record_end     = (prefix == '0);
            end
         end
         PH_VPAY: begin
            result.byte_role    = ROLE_PAYLOAD;
            result.field_number = field_ff;
            result.wire_type    = wt_ff;
            result.record_end   = v_stat.done;
         end
         PH_PAY: begin
            result.byte_role      = ROLE_PAYLOAD;
            result.field_number   = field_ff;
            result.wire_type      = wt_ff;
            result.payload_length = LEN_OUT_W'(decl_ff);
            result.record_end     = (remain_next == '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         cnt_ff   <= '0;
         acc_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         field_ff  <= field_in;
         wt_ff     <= wt_in;
         remain_ff <= remain_in;
         decl_ff   <= decl_in;
      end
   end

endmodule

// File: rtl/core/pbrs_out_reg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pbrs_out_reg
// Result register; loads a decoded item when empty or being drained.
// -----------------------------------------------------------------------------
module pbrs_out_reg import pbrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type result,
   output logic    take,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign take = in_valid && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: rtl/core/protobuf_record_splitter.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// protobuf_record_splitter
// Splits a serialized protobuf message, one byte per item, into records and
// labels every byte with its role, field number, wire type and length.
// -----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req_    | in  | req_valid/req_ready  | in_byte, message_last
//  rsp_    | out | rsp_valid/rsp_ready  | out_byte, byte_role, field_number,
//          |     |                      | wire_type, payload_length,
//          |     |                      | record_end, error_code
//
//  One item per cycle sustained while rsp_ready stays high; an item passes the
//  input register, then the result register. The record state updates once per byte.
//  Reset is synchronous; it empties both registers and returns to tag phase.
//  A stalled result holds in the result register while the input register
//  still takes one more item; req_ready drops once both are full.
// -----------------------------------------------------------------------------
module protobuf_record_splitter import pbrs_pkg::*; #(
   parameter int MAX_VARINT_BYTES = DEF_MAX_VARINT_BYTES,
   parameter int LENGTH_BITS      = DEF_LENGTH_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_message_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic [ROLE_W-1:0]    rsp_byte_role,
   output logic [FIELD_W-1:0]   rsp_field_number,
   output logic [WT_W-1:0]      rsp_wire_type,
   output logic [LEN_OUT_W-1:0] rsp_payload_length,
   output logic                 rsp_record_end,
   output logic [ERR_W-1:0]     rsp_error_code
);

   logic       take;
   logic       held_valid;
   logic [7:0] held_byte;
   logic       held_last;
   rsp_type    result;
   rsp_type    rsp_data;

   pbrs_in_reg u_in_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_message_last(req_message_last),
      .take            (take),
      .held_valid      (held_valid),
      .held_byte       (held_byte),
      .held_last       (held_last)
   );

   pbrs_decoder #(
      .MAX_VARINT_BYTES(MAX_VARINT_BYTES),
      .LENGTH_BITS     (LENGTH_BITS)
   ) u_decoder (
      .clock  (clock),
      .reset  (reset),
      .step   (take),
      .in_byte(held_byte),
      .in_last(held_last),
      .result (result)
   );

   pbrs_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (held_valid),
      .result   (result),
      .take     (take),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   assign rsp_out_byte       = rsp_data.out_byte;
   assign rsp_byte_role      = rsp_data.byte_role;
   assign rsp_field_number   = rsp_data.field_number;
   assign rsp_wire_type      = rsp_data.wire_type;
   assign rsp_payload_length = rsp_data.payload_length;
   assign rsp_record_end     = rsp_data.record_end;
   assign rsp_error_code     = rsp_data.error_code;

endmodule

// File: rtl/core/pbrs_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pbrs_checker
// Port-level checks for the protobuf record splitter, bound to the top level.
// -----------------------------------------------------------------------------
module pbrs_checker import pbrs_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [7:0]           req_in_byte,
   input logic                 req_message_last,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [7:0]           rsp_out_byte,
   input logic [ROLE_W-1:0]    rsp_byte_role,
   input logic [FIELD_W-1:0]   rsp_field_number,
   input logic [WT_W-1:0]      rsp_wire_type,
   input logic [LEN_OUT_W-1:0] rsp_payload_length,
   input logic                 rsp_record_end,
   input logic [ERR_W-1:0]     rsp_error_code
);

   // stalled result item must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_byte_role) && $stable(rsp_field_number) &&
      $stable(rsp_payload_length) && $stable(rsp_error_code))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // skipped bytes carry no record information
   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_role == ROLE_SKIP) |->
      (rsp_field_number == '0) && (rsp_wire_type == '0) &&
      (rsp_payload_length == '0) && !rsp_record_end && (rsp_error_code == ERR_NONE))
      else $error("skipped byte carries record data");

   a_err_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_NONE) |-> !rsp_record_end)
      else $error("record_end on error byte");

   // only group markers end a record on a tag byte
   a_tag_end_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_role == ROLE_TAG) && rsp_record_end |->
      (rsp_wire_type == WT_SGROUP) || (rsp_wire_type == WT_EGROUP))
      else $error("tag byte ends non-group record");

endmodule

bind protobuf_record_splitter pbrs_checker u_checker (.*);
